[rtl/core/fdcm_pkg.sv]
// Shared types and constants for the frame-difference change meter.
// No dependencies; imported by every module of the block.
package fdcm_pkg;

  // Frame store geometry
  localparam int MaxFramePixels = 1048576;
  localparam int AddrW          = $clog2(MaxFramePixels);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MaxFramePixels - 1);

  // Field widths
  localparam int PixW = 8;
  localparam int SumW = 28;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [PixW-1:0] MaskOn = {PixW{1'b1}};

  // Configuration register indexes
  localparam int CfgIdxW = 8;
  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANGE_THRESHOLD = 8'd0,
    REG_SHOW_CHANGES     = 8'd1,
    REG_SUM_DIFFS        = 8'd2
  } cfg_reg_t;

  localparam logic [PixW-1:0] ThresholdReset = 8'd10;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic [PixW-1:0] change_threshold;
    logic            show_changes;
    logic            sum_diffs;
  } cfg_t;

  // One pixel transfer heading for the difference stage
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
    logic            have_prev;
  } item_t;

endpackage

[rtl/core/fdcm_frame_store.sv]
// Previous-frame store: single-port synchronous RAM, read-first, with registered read data.
// Depends on fdcm_pkg for address and pixel widths.
module fdcm_frame_store
  import fdcm_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [AddrW-1:0] addr,
  input  logic [PixW-1:0]  wdata,
  output logic [PixW-1:0]  rdata
);

  logic [PixW-1:0] mem [MaxFramePixels];

  // Read old contents and write new pixel at the same address, same edge
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

[rtl/core/fdcm_diff_stage.sv]
// Difference stage: compares pixel with stored pixel, accumulates the frame sum,
// and holds the output register. Depends on fdcm_pkg types.
module fdcm_diff_stage
  import fdcm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  item_t           item_in,
  input  logic [PixW-1:0] prev_pixel,
  input  cfg_t            cfg,
  output logic            free,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PixW-1:0] out_pixel,
  output logic            frame_done,
  output logic [SumW-1:0] change_sum,
  output logic            sum_valid
);

  logic            s1_valid;
  item_t           s1_item;
  logic            move;
  logic [PixW-1:0] diff;
  logic [PixW-1:0] add;
  logic [SumW:0]   sum_wide;
  logic [SumW-1:0] sum_sat;
  logic [SumW-1:0] running_sum;
  logic [PixW-1:0] pix_next;

  assign move = s1_valid && (!out_valid || !out_stall);
  assign free = !s1_valid || move;

  // Absolute difference, change decision and contribution
  always_comb begin
    diff     = (s1_item.pixel > prev_pixel) ? (s1_item.pixel - prev_pixel)
                                            : (prev_pixel - s1_item.pixel);
    add      = (diff > cfg.change_threshold) ? (cfg.sum_diffs ? diff : MaskOn) : '0;
    sum_wide = {1'b0, running_sum} + {{(SumW + 1 - PixW){1'b0}}, add};
    sum_sat  = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
    pix_next = (s1_item.have_prev && cfg.show_changes) ? add : s1_item.pixel;
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
    if (load) begin
      s1_item <= item_in;
    end
  end

  // Frame accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (move) begin
      if (s1_item.last) begin
        running_sum <= '0;
      end else if (s1_item.have_prev) begin
        running_sum <= sum_sat;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (move) begin
      out_pixel  <= pix_next;
      frame_done <= s1_item.last;
      sum_valid  <= s1_item.last && s1_item.have_prev;
      change_sum <= (s1_item.last && s1_item.have_prev) ? sum_sat : '0;
    end
  end

`ifndef SYNTHESIS
  a_sum_valid_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && sum_valid |-> frame_done)
    else $error("sum_valid without frame_done");
  a_sum_zero_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sum_valid |-> change_sum == '0)
    else $error("change_sum nonzero without sum_valid");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("stage overrun");
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    move && s1_item.last |=> running_sum == '0)
    else $error("accumulator not cleared at frame end");
`endif

endmodule

[rtl/core/frame_difference_change_meter_top.sv]
// Top level of the frame-difference change meter: config registers, pixel counter,
// frame store and difference stage. Depends on fdcm_pkg, fdcm_frame_store, fdcm_diff_stage.
//
// Accepts one 8-bit luma pixel per clock, back to back, unless the output stalls, and
// gives one result per pixel from its output register. Each transfer reads the stored
// pixel of the previous frame and writes the new one into the same entry of a 1M x 8
// single-port RAM in one edge (read-first), so consecutive pixels, including one-pixel
// frames, never conflict. Sustained rate, set by the single RAM port, is one pixel per
// clock unless the output stalls. The frame store has no reset; a frame longer than
// every earlier frame compares against stale data. Configuration writes are always
// ready and take effect on the next pixel; write them only while no pixel is in flight.
module frame_difference_change_meter_top
  import fdcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PixW-1:0]    pixel_value,
  input  logic               frame_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PixW-1:0]    out_pixel,
  output logic               frame_done,
  output logic [SumW-1:0]    change_sum,
  output logic               sum_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [PixW-1:0]    cfg_data
);

  cfg_t             cfg;
  logic [AddrW-1:0] pixel_index;
  logic             have_previous;
  logic             accept;
  logic             stage_free;
  logic [PixW-1:0]  prev_pixel;
  item_t            item;

  assign cfg_ready = 1'b1;
  assign in_stall  = !stage_free;
  assign accept    = in_valid && stage_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.change_threshold <= ThresholdReset;
      cfg.show_changes     <= 1'b0;
      cfg.sum_diffs        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHANGE_THRESHOLD: cfg.change_threshold <= cfg_data;
        REG_SHOW_CHANGES:     cfg.show_changes     <= cfg_data[0];
        REG_SUM_DIFFS:        cfg.sum_diffs        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Raster position and previous-frame flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index   <= '0;
      have_previous <= 1'b0;
    end else if (accept) begin
      if (frame_last) begin
        pixel_index   <= '0;
        have_previous <= 1'b1;
      end else if (pixel_index == LastAddr) begin
        pixel_index <= '0;
      end else begin
        pixel_index <= pixel_index + 1'b1;
      end
    end
  end

  assign item = '{pixel: pixel_value, last: frame_last, have_prev: have_previous};

  fdcm_frame_store u_store (
    .clk   (clk),
    .en    (accept),
    .addr  (pixel_index),
    .wdata (pixel_value),
    .rdata (prev_pixel)
  );

  fdcm_diff_stage u_diff (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .item_in    (item),
    .prev_pixel (prev_pixel),
    .cfg        (cfg),
    .free       (stage_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pixel  (out_pixel),
    .frame_done (frame_done),
    .change_sum (change_sum),
    .sum_valid  (sum_valid)
  );

`ifndef SYNTHESIS
  a_index_reset_at_end: assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |=> pixel_index == '0 && have_previous)
    else $error("index not restarted after frame end");
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(pixel_index))
    else $error("index moved without a transfer");
  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");
`endif

endmodule

[verif/frame_difference_change_meter_top_tb.sv]
// Self-checking testbench for frame_difference_change_meter_top.
// Depends on fdcm_pkg and the RTL of the block; predicts every pixel result
// from its own frame store copy and checks each output transfer field by field.
`timescale 1ns / 100ps

module frame_difference_change_meter_top_tb;
  import fdcm_pkg::*;

  localparam int LongestFrame  = 16;     // first frame sets how far later frames may reach
  localparam int PhaseCount    = 9;
  localparam int PhasePixels   = 155;
  localparam int DrainCycles   = 8;
  localparam int LongHold      = 300;
  localparam int WatchdogLimit = 2000;
  localparam logic [CfgIdxW-1:0] NoSuchReg = 8'hFF;

  // First frame after reset: every pixel passes through unchanged
  localparam logic [15:0][PixW-1:0] FirstFrame = {
    8'hC3, 8'h02, 8'h04, 8'h08, 8'h40, 8'h20, 8'h10, 8'h7F,
    8'hFE, 8'h01, 8'hAA, 8'h55, 8'h80, 8'h0A, 8'hFF, 8'h00
  };

  typedef struct packed {
    logic [PixW-1:0] out_pixel;
    logic            frame_done;
    logic [SumW-1:0] change_sum;
    logic            sum_valid;
  } pix_result_t;

  typedef enum logic [0:0] {ROW_PIXEL, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic [7:0]      a;      // pixel value or register index
    logic [7:0]      b;      // frame_last or write data
    bit              typed;
    pix_result_t     want;
  } stim_row_t;

  // DUT signals
  logic               clk;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [PixW-1:0]    pixel_value = '0;
  logic               frame_last  = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b1;
  logic [PixW-1:0]    out_pixel;
  logic               frame_done;
  logic [SumW-1:0]    change_sum;
  logic               sum_valid;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [PixW-1:0]    cfg_data    = '0;

  // Predictor state
  logic [PixW-1:0]    prior_frame [int];
  bit                 have_prior  = 1'b0;
  logic [AddrW-1:0]   pos         = '0;
  logic [SumW-1:0]    sum_acc     = '0;
  logic [PixW-1:0]    cfg_thr     = ThresholdReset;
  logic               cfg_show    = 1'b0;
  logic               cfg_mode    = 1'b0;

  pix_result_t        expected_results [$];
  stim_row_t          directed_rows [$];

  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  bit                 long_hold_req  = 1'b0;
  bit                 long_hold_done = 1'b0;
  int                 mismatches     = 0;
  int                 pixels_sent    = 0;
  int                 frames_sent    = 0;
  int                 cfg_writes     = 0;
  int                 sums_checked   = 0;
  int                 idle_cycles    = 0;

  frame_difference_change_meter_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .frame_last  (frame_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pixel   (out_pixel),
    .frame_done  (frame_done),
    .change_sum  (change_sum),
    .sum_valid   (sum_valid),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Frame differencing predictor: compare with the stored pixel, accumulate, store
  function automatic pix_result_t predict_pixel(input logic [PixW-1:0] pix, input logic last);
    pix_result_t     r;
    logic [PixW-1:0] prev;
    logic [PixW-1:0] delta;
    logic [PixW-1:0] add;
    logic [SumW:0]   wide;
    prev         = prior_frame.exists(int'(pos)) ? prior_frame[int'(pos)] : '0;
    r.out_pixel  = pix;
    r.frame_done = last;
    r.change_sum = '0;
    r.sum_valid  = 1'b0;
    if (have_prior) begin
      delta = (pix > prev) ? pix - prev : prev - pix;
      add   = (delta > cfg_thr) ? (cfg_mode ? delta : MaskOn) : '0;
      wide  = sum_acc + add;
      sum_acc = (wide > SumMax) ? SumMax : wide[SumW-1:0];
      if (cfg_show) r.out_pixel = add;
    end
    prior_frame[int'(pos)] = pix;
    if (last) begin
      if (have_prior) begin
        r.change_sum = sum_acc;
        r.sum_valid  = 1'b1;
      end
      have_prior = 1'b1;
      pos        = '0;
      sum_acc    = '0;
    end else begin
      pos = pos + 1'b1;
    end
    return r;
  endfunction

  function automatic void add_pixel(input logic [7:0] pix, input logic last);
    stim_row_t row;
    row.kind  = ROW_PIXEL;
    row.a     = pix;
    row.b     = {7'd0, last};
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [7:0] pix, input logic last,
                                    input logic [PixW-1:0] outp, input logic [SumW-1:0] sum,
                                    input logic valid);
    stim_row_t row;
    row.kind  = ROW_PIXEL;
    row.a     = pix;
    row.b     = {7'd0, last};
    row.typed = 1'b1;
    row.want  = '{out_pixel: outp, frame_done: last, change_sum: sum, sum_valid: valid};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.a     = idx;
    row.b     = data;
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endfunction

  // One pixel transfer; an optional gap first, valid stays up into the next call
  task automatic send_pixel(input logic [PixW-1:0] pix, input logic last,
                            input bit typed, input pix_result_t want);
    pix_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= pix;
    frame_last  <= last;
    do @(posedge clk); while (in_stall);
    predicted = predict_pixel(pix, last);
    expected_results.push_back(typed ? want : predicted);
    pixels_sent++;
    if (last) frames_sent++;
  endtask

  // Drop valid and let every pixel in flight come out
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CHANGE_THRESHOLD: cfg_thr  = data;
      REG_SHOW_CHANGES:     cfg_show = data[0];
      REG_SUM_DIFFS:        cfg_mode = data[0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random frames: mostly the stored frame with local changes, some pure noise
  task automatic run_frames(input int goal);
    int sent;
    int len;
    int style;
    int r;
    int v;
    sent = 0;
    while (sent < goal) begin
      r     = $urandom_range(9);
      len   = (r == 0) ? 1 : (r == 1) ? LongestFrame : $urandom_range(LongestFrame, 2);
      style = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        v = prior_frame[i];
        r = $urandom_range(99);
        if (style == 0 || r >= 80) begin
          v = $urandom_range(255);
        end else if (r >= 40) begin
          v = v + int'($urandom_range(60)) - 30;
          if (v < 0) v = 0;
          else if (v > 255) v = 255;
        end
        send_pixel(8'(v), i == len - 1, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  // Receiver: random stalls plus one long hold-off counted here
  initial begin : receiver
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        hold_cycles    = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker: each output transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: out_pixel %0d frame_done %0b", out_pixel,
               frame_done);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_pixel !== want.out_pixel) begin
          $error("out_pixel: expected %0d, got %0d", want.out_pixel, out_pixel);
          mismatches++;
        end
        if (frame_done !== want.frame_done) begin
          $error("frame_done: expected %0b, got %0b", want.frame_done, frame_done);
          mismatches++;
        end
        if (change_sum !== want.change_sum) begin
          $error("change_sum: expected %0d, got %0d", want.change_sum, change_sum);
          mismatches++;
        end
        if (sum_valid !== want.sum_valid) begin
          $error("sum_valid: expected %0b, got %0b", want.sum_valid, sum_valid);
          mismatches++;
        end
        if (want.frame_done && want.sum_valid) sums_checked++;
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("frame_difference_change_meter_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t row;

    // Directed table: first frame, reset settings, then map modes and extremes
    for (int i = 0; i < LongestFrame; i++) begin
      add_typed(FirstFrame[i], i == LongestFrame - 1, FirstFrame[i], '0, 1'b0);
    end
    add_typed(8'd255, 1'b0, 8'd255, '0, 1'b0);
    add_typed(8'd0,   1'b0, 8'd0,   '0, 1'b0);
    add_typed(8'd20,  1'b0, 8'd20,  '0, 1'b0);
    add_typed(8'd138, 1'b1, 8'd138, 28'd510, 1'b1);
    add_cfg(REG_CHANGE_THRESHOLD, 8'h00);
    add_cfg(REG_SHOW_CHANGES, 8'h03);        // upper bits are dropped
    add_cfg(REG_SUM_DIFFS, 8'h01);
    add_cfg(NoSuchReg, 8'hFF);               // index outside the map is ignored
    add_pixel(8'd254, 1'b0);
    add_pixel(8'd0,   1'b0);
    add_pixel(8'd200, 1'b1);
    add_cfg(REG_CHANGE_THRESHOLD, 8'hFF);
    add_cfg(REG_SUM_DIFFS, 8'h00);
    // no difference can exceed the top threshold: empty mask, zero sum
    add_typed(8'd0, 1'b1, 8'd0, '0, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.a, row.b);
      end else begin
        send_pixel(row.a, row.b[0], row.typed, row.want);
      end
    end
    settle();

    // Random phases, three idle patterns, all map and count modes
    for (int p = 0; p < PhaseCount; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct  = 23;
          recv_stall_pct = 71;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 23;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (p == 0) write_reg(REG_CHANGE_THRESHOLD, 8'h00);
      else if (p == 3) write_reg(REG_CHANGE_THRESHOLD, 8'hFF);
      else if (p == 6) write_reg(REG_CHANGE_THRESHOLD, 8'h01);
      else if ($urandom_range(1)) write_reg(REG_CHANGE_THRESHOLD, 8'($urandom_range(40)));
      else write_reg(REG_CHANGE_THRESHOLD, 8'($urandom_range(255)));
      write_reg(REG_SHOW_CHANGES, {7'($urandom), p[0]});
      write_reg(REG_SUM_DIFFS, {7'($urandom), p[1]});
      if (p == PhaseCount - 1) long_hold_req = 1'b1;
      run_frames(PhasePixels);
      settle();
    end

    $display("Sent %0d pixels in %0d frames with %0d register writes;", pixels_sent,
             frames_sent, cfg_writes);
    $display("checked %0d valid frame sums across threshold, mask and sum modes.",
             sums_checked);
    if (mismatches == 0) begin
      $display("frame_difference_change_meter_top test passed");
    end else begin
      $display("frame_difference_change_meter_top test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fdcm_pkg.sv
rtl/core/fdcm_frame_store.sv
rtl/core/fdcm_diff_stage.sv
rtl/core/frame_difference_change_meter_top.sv
verif/frame_difference_change_meter_top_tb.sv
